>>> rtl/core/nsc_pkg.sv
// nmea sentence checker package: byte classes, queue item, config and result types
// used by every module of the block; no dependencies
package nsc_pkg;

  localparam int unsigned LineBufferSize = 192;
  localparam int unsigned QueueDepth     = 4;

  localparam logic [7:0] MinLenReset = 8'd6;
  localparam logic [7:0] MaxLenReset = 8'(LineBufferSize - 1);

  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegMinLength = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxLength = CfgIdxW'(1);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPrLo   = 8'd32;
  localparam logic [7:0] ChPrHi   = 8'd126;

  typedef enum logic [1:0] {
    ClsDollar,
    ClsTerm,
    ClsPrint,
    ClsOther
  } byte_cls_e;

  typedef struct packed {
    byte_cls_e  cls;
    logic [7:0] data;
    logic       hex_ok;
    logic [3:0] hex_nib;
  } item_t;

  typedef struct packed {
    logic [7:0] min_length;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        sentence_valid;
    logic [7:0]  sentence_length;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic [31:0] valid_total;
    logic [31:0] invalid_total;
  } result_t;

endpackage

>>> rtl/core/nmea_sentence_checker_top.sv
// nmea sentence checker top: config registers, front end, queue, back end
// a byte accepted into the queue is registered there before the back end can pop it; its result,
// if any, is registered in the back end's result register when that byte is popped
// throughput: one byte per cycle while the queue is not full and no result is held by a stall
// reset: empties the queue, clears sentence state and counters, loads min 6 and max 191
module nmea_sentence_checker_top #(
  parameter int unsigned QUEUE_DEPTH = nsc_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        sentence_valid_o,
  output logic [7:0]                  sentence_length_o,
  output logic [7:0]                  computed_sum_o,
  output logic [7:0]                  received_sum_o,
  output logic [31:0]                 valid_total_o,
  output logic [31:0]                 invalid_total_o
);

  nsc_pkg::cfg_t    cfg_q, cfg_d;
  nsc_pkg::item_t   push_item, pop_item;
  nsc_pkg::result_t result;
  logic             push, pop, q_empty, q_full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nsc_pkg::RegMinLength: cfg_d.min_length = cfg_data_i;
        nsc_pkg::RegMaxLength: cfg_d.max_length = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length <= nsc_pkg::MinLenReset;
      cfg_q.max_length <= nsc_pkg::MaxLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nsc_front u_front (
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .item_o     (push_item)
  );

  nsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  nsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (pop_item),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign sentence_valid_o  = result.sentence_valid;
  assign sentence_length_o = result.sentence_length;
  assign computed_sum_o    = result.computed_sum;
  assign received_sum_o    = result.received_sum;
  assign valid_total_o     = result.valid_total;
  assign invalid_total_o   = result.invalid_total;

  // a passing sentence always matches its sums and holds at least dollar, star, two digits
  a_valid_sums_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_valid_o |-> computed_sum_o == received_sum_o)
    else $error("valid sentence with mismatched sums");

  a_valid_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_valid_o |-> sentence_length_o >= 8'd4)
    else $error("valid sentence too short");

  // the back end never pops an empty queue and never overwrites a held result
  a_pop_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty && !(out_valid_o && out_stall_i))
    else $error("pop while queue empty or result held");

endmodule

>>> rtl/core/nsc_front.sv
// nmea sentence checker front end: classifies each received byte and decodes hex
// depends on nsc_pkg
module nsc_front (
  input  logic            in_valid_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output nsc_pkg::item_t  item_o
);

  nsc_pkg::byte_cls_e cls;
  logic               hex_ok;
  logic [3:0]         hex_nib;

  always_comb begin
    if (rx_byte_i == nsc_pkg::ChDollar) begin
      cls = nsc_pkg::ClsDollar;
    end else if (rx_byte_i == nsc_pkg::ChCr || rx_byte_i == nsc_pkg::ChLf) begin
      cls = nsc_pkg::ClsTerm;
    end else if (rx_byte_i >= nsc_pkg::ChPrLo && rx_byte_i <= nsc_pkg::ChPrHi) begin
      cls = nsc_pkg::ClsPrint;
    end else begin
      cls = nsc_pkg::ClsOther;
    end
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) begin
      hex_nib = 4'(rx_byte_i - 8'h30);
    end else if (rx_byte_i >= 8'h41 && rx_byte_i <= 8'h46) begin
      hex_nib = 4'(rx_byte_i - 8'h37);
    end else if (rx_byte_i >= 8'h61 && rx_byte_i <= 8'h66) begin
      hex_nib = 4'(rx_byte_i - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign in_stall_o      = q_full_i;
  assign push_o          = in_valid_i && !q_full_i;
  assign item_o.cls      = cls;
  assign item_o.data     = rx_byte_i;
  assign item_o.hex_ok   = hex_ok;
  assign item_o.hex_nib  = hex_nib;

endmodule

>>> rtl/core/nsc_queue.sv
// nmea sentence checker queue: small register fifo between front end and back end
// depends on nsc_pkg
module nsc_queue #(
  parameter int unsigned DEPTH = nsc_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nsc_pkg::item_t  item_i,
  input  logic            pop_i,
  output nsc_pkg::item_t  item_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  nsc_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign empty_o = (count_q == CW'(0));
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/nsc_back.sv
// nmea sentence checker back end: sentence state, checksum compare, counters, result register
// depends on nsc_pkg
module nsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsc_pkg::cfg_t    cfg_i,
  input  nsc_pkg::item_t   item_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output nsc_pkg::result_t result_o
);

  logic        collecting_q, collecting_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic        star_q, star_d;
  logic [1:0]  digits_q, digits_d;
  logic        bad_q, bad_d;
  logic [7:0]  dval_q, dval_d;
  logic [31:0] vcnt_q, vcnt_d;
  logic [31:0] icnt_q, icnt_d;
  logic        out_valid_q, out_valid_d;
  nsc_pkg::result_t res_q, res_d;

  logic       slot_free;
  logic       sum_ok;
  logic [7:0] rsum;
  logic       good;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = slot_free && !q_empty_i;

  assign sum_ok = star_q && (digits_q == 2'd2) && !bad_q;
  assign rsum   = sum_ok ? dval_q : 8'd0;
  assign good   = sum_ok && (rsum == xor_q);

  always_comb begin
    collecting_d = collecting_q;
    len_d        = len_q;
    xor_d        = xor_q;
    star_d       = star_q;
    digits_d     = digits_q;
    bad_d        = bad_q;
    dval_d       = dval_q;
    vcnt_d       = vcnt_q;
    icnt_d       = icnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_d        = res_q;
    if (pop_o) begin
      if (item_i.cls == nsc_pkg::ClsDollar) begin
        collecting_d = 1'b1;
        len_d        = 8'd1;
        xor_d        = 8'd0;
        star_d       = 1'b0;
        digits_d     = 2'd0;
        bad_d        = 1'b0;
        dval_d       = 8'd0;
      end else if (collecting_q) begin
        if (item_i.cls == nsc_pkg::ClsPrint && len_q < cfg_i.max_length) begin
          len_d = len_q + 8'd1;
          if (!star_q) begin
            if (item_i.data == nsc_pkg::ChStar) begin
              star_d = 1'b1;
            end else begin
              xor_d = xor_q ^ item_i.data;
            end
          end else if (digits_q != 2'd2) begin
            if (!item_i.hex_ok) begin
              bad_d = 1'b1;
            end else begin
              dval_d = {dval_q[3:0], item_i.hex_nib};
            end
            digits_d = digits_q + 2'd1;
          end
        end else begin
          // terminator, non-printable byte or length overflow
          if (item_i.cls == nsc_pkg::ClsTerm && len_q > cfg_i.min_length) begin
            if (good) begin
              vcnt_d = vcnt_q + 32'd1;
            end else begin
              icnt_d = icnt_q + 32'd1;
            end
            out_valid_d           = 1'b1;
            res_d.sentence_valid  = good;
            res_d.sentence_length = len_q;
            res_d.computed_sum    = xor_q;
            res_d.received_sum    = rsum;
            res_d.valid_total     = vcnt_d;
            res_d.invalid_total   = icnt_d;
          end
          collecting_d = 1'b0;
          len_d        = 8'd0;
          xor_d        = 8'd0;
          star_d       = 1'b0;
          digits_d     = 2'd0;
          bad_d        = 1'b0;
          dval_d       = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      len_q        <= '0;
      xor_q        <= '0;
      star_q       <= 1'b0;
      digits_q     <= '0;
      bad_q        <= 1'b0;
      dval_q       <= '0;
      vcnt_q       <= '0;
      icnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      len_q        <= len_d;
      xor_q        <= xor_d;
      star_q       <= star_d;
      digits_q     <= digits_d;
      bad_q        <= bad_d;
      dval_q       <= dval_d;
      vcnt_q       <= vcnt_d;
      icnt_q       <= icnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

>>> tb/nsc_report_checker.sv
// nmea sentence checker testbench: channel monitor with its own sentence predictor
// predicts each report from the accepted bytes and register writes, compares field by field
// depends on nsc_pkg for register indexes, byte codes and the report type
module nsc_report_checker
  import nsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               sentence_valid_i,
  input  logic [7:0]         sentence_length_i,
  input  logic [7:0]         computed_sum_i,
  input  logic [7:0]         received_sum_i,
  input  logic [31:0]        valid_total_i,
  input  logic [31:0]        invalid_total_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  min_len = MinLenReset;
  logic [7:0]  max_len = MaxLenReset;
  logic        in_sentence = 1'b0;
  logic [7:0]  len_so_far = '0;
  logic [7:0]  xor_so_far = '0;
  logic        star_found = 1'b0;
  logic [1:0]  digit_count = '0;
  logic        digit_error = 1'b0;
  logic [7:0]  digit_acc = '0;
  logic [31:0] good_total = '0;
  logic [31:0] bad_total = '0;
  result_t     sentence_reports[$];
  int unsigned errors = 0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function void clear_sentence();
    len_so_far  = '0;
    xor_so_far  = '0;
    star_found  = 1'b0;
    digit_count = '0;
    digit_error = 1'b0;
    digit_acc   = '0;
  endfunction

  task automatic advance_sentence(input logic [7:0] b);
    logic    sum_ok;
    int      nib;
    result_t rep;
    if (b == ChDollar) begin
      clear_sentence();
      in_sentence = 1'b1;
      len_so_far  = 8'd1;
    end else if (in_sentence) begin
      if (b == ChCr || b == ChLf) begin
        if (len_so_far > min_len) begin
          sum_ok = star_found && digit_count == 2'd2 && !digit_error;
          rep.received_sum    = sum_ok ? digit_acc : 8'd0;
          rep.sentence_valid  = sum_ok && rep.received_sum == xor_so_far;
          if (rep.sentence_valid) good_total = good_total + 32'd1;
          else bad_total = bad_total + 32'd1;
          rep.sentence_length = len_so_far;
          rep.computed_sum    = xor_so_far;
          rep.valid_total     = good_total;
          rep.invalid_total   = bad_total;
          sentence_reports.push_back(rep);
        end
        in_sentence = 1'b0;
        clear_sentence();
      end else if (b >= ChPrLo && b <= ChPrHi && len_so_far < max_len) begin
        len_so_far = len_so_far + 8'd1;
        if (!star_found) begin
          if (b == ChStar) star_found = 1'b1;
          else xor_so_far = xor_so_far ^ b;
        end else if (digit_count < 2'd2) begin
          nib = hex_value(b);
          if (nib < 0) digit_error = 1'b1;
          else digit_acc = {digit_acc[3:0], 4'(nib)};
          digit_count = digit_count + 2'd1;
        end
      end else begin
        in_sentence = 1'b0;
        clear_sentence();
      end
    end
  endtask

  task automatic check_report();
    result_t want;
    if (sentence_reports.size() == 0) begin
      $error("report with no sentence pending");
      errors++;
    end else begin
      want = sentence_reports.pop_front();
      if (sentence_valid_i !== want.sentence_valid) begin
        $error("sentence_valid: expected %0d, got %0d", want.sentence_valid, sentence_valid_i);
        errors++;
      end
      if (sentence_length_i !== want.sentence_length) begin
        $error("sentence_length: expected %0d, got %0d", want.sentence_length,
               sentence_length_i);
        errors++;
      end
      if (computed_sum_i !== want.computed_sum) begin
        $error("computed_sum: expected %0h, got %0h", want.computed_sum, computed_sum_i);
        errors++;
      end
      if (received_sum_i !== want.received_sum) begin
        $error("received_sum: expected %0h, got %0h", want.received_sum, received_sum_i);
        errors++;
      end
      if (valid_total_i !== want.valid_total) begin
        $error("valid_total: expected %0d, got %0d", want.valid_total, valid_total_i);
        errors++;
      end
      if (invalid_total_i !== want.invalid_total) begin
        $error("invalid_total: expected %0d, got %0d", want.invalid_total, invalid_total_i);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len     = MinLenReset;
      max_len     = MaxLenReset;
      in_sentence = 1'b0;
      clear_sentence();
      good_total  = '0;
      bad_total   = '0;
      sentence_reports.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegMinLength: min_len = cfg_data_i;
          RegMaxLength: max_len = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_report();
      if (in_valid_i && !in_stall_i) advance_sentence(rx_byte_i);
      pending_o    <= sentence_reports.size();
      fail_count_o <= errors;
    end
  end

endmodule

>>> tb/tb_top.sv
// nmea sentence checker testbench top: clock, reset, byte and register stimulus, verdict
// drives framed sentences with random content and noise under bursty traffic and stalls
// depends on nsc_pkg, nmea_sentence_checker_top and nsc_report_checker
module tb_top;
  import nsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseBytes  = 150;
  localparam int unsigned DrainCycles = QueueDepth + 6;
  localparam int unsigned IdleLimit   = 2000;

  typedef enum {
    StallNone,
    StallSparse,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  typedef enum {
    KindGood,
    KindWrongSum,
    KindOneDigit,
    KindStarOnly,
    KindNoStar,
    KindBadDigit,
    KindNoiseEnd,
    KindRestart,
    KindIdleNoise,
    KindTrailing
  } sentence_kind_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               sentence_valid;
  logic [7:0]         sentence_length;
  logic [7:0]         computed_sum;
  logic [7:0]         received_sum;
  logic [31:0]        valid_total;
  logic [31:0]        invalid_total;
  int unsigned        fail_count;
  int unsigned        pending;

  int unsigned        bytes_sent = 0;
  int unsigned        burst_left = 0;
  bit                 steady = 1'b0;
  int unsigned        idle_cycles = 0;
  stall_mode_e        stall_mode = StallNone;
  int unsigned        stall_left = 0;

  nmea_sentence_checker_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .sentence_valid_o (sentence_valid),
    .sentence_length_o(sentence_length),
    .computed_sum_o   (computed_sum),
    .received_sum_o   (received_sum),
    .valid_total_o    (valid_total),
    .invalid_total_o  (invalid_total)
  );

  nsc_report_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sentence_valid_i (sentence_valid),
    .sentence_length_i(sentence_length),
    .computed_sum_i   (computed_sum),
    .received_sum_i   (received_sum),
    .valid_total_i    (valid_total),
    .invalid_total_i  (invalid_total),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern; a random mode is held for a random span, then picked anew
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(32, 400);
    end
    stall_left--;
    case (stall_mode)
      StallNone:     out_stall <= 1'b0;
      StallSparse:   out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy:    out_stall <= ($urandom_range(0, 1) == 0);
      StallPeriodic: out_stall <= (stall_left % 16) < 6;
      default:       out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return 8'(int'("0") + nib);
    return 8'((lower ? int'("a") : int'("A")) + nib - 10);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    burst_left--;
    bytes_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic set_config(input logic [7:0] min_len, input logic [7:0] max_len);
    cfg_valid <= 1'b1;
    cfg_index <= RegMinLength;
    cfg_data  <= min_len;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= RegMaxLength;
    cfg_data  <= max_len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic sentence_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return KindGood;
    if (r < 62) return KindWrongSum;
    if (r < 66) return KindOneDigit;
    if (r < 70) return KindStarOnly;
    if (r < 76) return KindNoStar;
    if (r < 82) return KindBadDigit;
    if (r < 86) return KindNoiseEnd;
    if (r < 90) return KindRestart;
    if (r < 94) return KindIdleNoise;
    return KindTrailing;
  endfunction

  task automatic send_sentence();
    sentence_kind_e kind;
    int unsigned    body_len;
    logic [7:0]     b;
    logic [7:0]     sum;
    logic [7:0]     sent_sum;
    bit             lower;
    kind     = pick_kind();
    body_len = ($urandom_range(0, 15) == 0) ? $urandom_range(150, 253) : $urandom_range(0, 14);
    lower    = $urandom_range(0, 1);
    sum      = '0;
    if (kind == KindIdleNoise) begin
      repeat ($urandom_range(1, 3)) begin
        b = $urandom_range(0, 255);
        send_byte(b == ChDollar ? ChStar : b);
      end
    end
    send_byte(ChDollar);
    for (int i = 0; i < body_len; i++) begin
      b = $urandom_range(ChPrLo, ChPrHi);
      if (b == ChDollar || b == ChStar) b = ",";
      if (kind == KindRestart && i == body_len / 2) begin
        b   = ChDollar;
        sum = '0;
      end else begin
        sum = sum ^ b;
      end
      send_byte(b);
    end
    sent_sum = (kind == KindWrongSum) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    case (kind)
      KindNoStar: ;
      KindStarOnly: send_byte(ChStar);
      KindOneDigit: begin
        send_byte(ChStar);
        send_byte(hex_char(sent_sum[7:4], lower));
      end
      KindBadDigit: begin
        send_byte(ChStar);
        b = ($urandom_range(0, 3) == 0) ? ChStar : 8'($urandom_range(8'h47, 8'h5A));
        if ($urandom_range(0, 1) == 0) begin
          send_byte(b);
          send_byte(hex_char(sent_sum[3:0], lower));
        end else begin
          send_byte(hex_char(sent_sum[7:4], lower));
          send_byte(b);
        end
      end
      default: begin
        send_byte(ChStar);
        send_byte(hex_char(sent_sum[7:4], lower));
        send_byte(hex_char(sent_sum[3:0], !lower ^ ($urandom_range(0, 1) == 0)));
      end
    endcase
    if (kind == KindTrailing) begin
      repeat ($urandom_range(1, 4)) begin
        b = $urandom_range(ChPrLo, ChPrHi);
        send_byte(b == ChDollar ? ChStar : b);
      end
    end
    if (kind == KindNoiseEnd) send_byte($urandom_range(0, 255));
    send_byte(($urandom_range(0, 1) == 0) ? ChCr : ChLf);
  endtask

  initial begin
    logic [7:0]  min_len;
    logic [7:0]  max_len;
    int unsigned phase_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short sentences with min length 0 so each one ended by CR or LF is reported
    set_config(8'd0, MaxLenReset);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$A*41x");
    send_byte(ChCr);
    send_text("$j*6a");
    send_byte(ChLf);
    send_text("$~");
    send_byte(ChCr);
    send_text("$*F*");
    send_byte(ChLf);
    send_text("$$");
    send_byte(8'h7F);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: begin min_len = MinLenReset; max_len = MaxLenReset; end
        1: begin min_len = 8'd0;        max_len = 8'd0;        end
        2: begin min_len = 8'd255;      max_len = 8'd255;      end
        3: begin min_len = 8'd4;        max_len = 8'd12;       end
        4: begin min_len = 8'd0;        max_len = 8'd255;      end
        5: begin
          min_len = $urandom_range(0, 24);
          max_len = $urandom_range(1, 255);
        end
        default: begin
          min_len = $urandom_range(0, 12);
          max_len = $urandom_range(24, 80);
        end
      endcase
      set_config(min_len, max_len);
      steady      = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_sentence();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
